### rtl/core/avr_pkg.sv
// ----------------------------------------------------------------------------
// avr_pkg: shared types and constants of the axis vector rotator
// Request structs, datapath widths, axis codes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package avr_pkg;

    // axis codes of axis_select
    localparam logic [1:0] AXIS_0    = 2'd0;
    localparam logic [1:0] AXIS_1    = 2'd1;
    localparam logic [1:0] AXIS_2    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // CORDIC datapath: 24 fraction bits, magnitude up to about 2^55.5
    localparam int unsigned CORDIC_W = 58;
    localparam int unsigned ANGLE_W  = 34;
    localparam int unsigned FRAC_W   = 24;
    localparam int unsigned PROD_W   = 65;

    // CORDIC gain 0.60725293500888 in Q32
    localparam logic signed [32:0] GAIN_Q32 = 33'sd2608131496;

    // atan(2^-i) in units of 2^-32 turn, rounded to nearest
    localparam int unsigned ATAN_N = 32;
    localparam logic [31:0] ATAN_TABLE [ATAN_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // input request
    typedef struct packed {
        logic signed [31:0] comp_0;
        logic signed [31:0] comp_1;
        logic signed [31:0] comp_2;
        logic        [31:0] turn_angle;
        logic        [1:0]  axis_select;
    } t_in_req;

    // output request
    typedef struct packed {
        logic signed [31:0] out_0;
        logic signed [31:0] out_1;
        logic signed [31:0] out_2;
        logic               saturated;
    } t_out_req;

    // raw vector and axis carried beside the rotation datapath
    typedef struct packed {
        logic signed [31:0] comp_0;
        logic signed [31:0] comp_1;
        logic signed [31:0] comp_2;
        logic        [1:0]  axis_select;
    } t_side;

    // rotating pair and residual angle handed from cell to cell
    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [ANGLE_W-1:0]  z;
    } t_cord;

endpackage

### rtl/core/axis_vector_rotator.sv
// ----------------------------------------------------------------------------
// axis_vector_rotator: CORDIC rotation of a 3-vector about one axis
// CORDIC cell pipe after a gain prescale; one request a cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_req  (t_in_req)
//  out     | output    | o_out_valid / i_out_ready  | o_out_req (t_out_req)
//
//  one request per cycle unless the output stalls; registers in order:
//  multiply, quadrant fold, one per CORDIC cell, round and clip
//  a stall at the output freezes the whole pipe; one more request is held
//  in an input skid register, so o_in_ready is a register output
//  synchronous active-low reset clears all valid bits and the skid
// ----------------------------------------------------------------------------
module axis_vector_rotator #(
    parameter int unsigned CORDIC_STAGES = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  avr_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output avr_pkg::t_out_req o_out_req
);

    logic             w_en;
    logic             w_in_acc;
    logic             r_skid_valid;
    avr_pkg::t_in_req r_skid_req;
    logic             w_head_valid;
    avr_pkg::t_in_req w_head_req;

    logic             w_valid [CORDIC_STAGES+1];
    avr_pkg::t_cord   w_cord  [CORDIC_STAGES+1];
    avr_pkg::t_side   w_side  [CORDIC_STAGES+1];

    // pipe advances when the output register is free or being taken
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = !r_skid_valid;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // skid first, then the port
    assign w_head_valid = r_skid_valid || w_in_acc;
    assign w_head_req   = r_skid_valid ? r_skid_req : i_in_req;

    // skid register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            r_skid_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    // skid register payload
    always_ff @(posedge i_clk) begin
        if (!w_en && w_in_acc) begin
            r_skid_req <= i_in_req;
        end
    end

    // prescale and quadrant fold
    avr_prescale u_prescale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_head_valid),
        .i_req   (w_head_req),
        .o_valid (w_valid[0]),
        .o_cord  (w_cord[0]),
        .o_side  (w_side[0])
    );

    // row of CORDIC cells
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        avr_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_cord  (w_cord[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_cord  (w_cord[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    // round, clip and output register
    avr_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_valid[CORDIC_STAGES]),
        .i_cord  (w_cord[CORDIC_STAGES]),
        .i_side  (w_side[CORDIC_STAGES]),
        .o_valid (o_out_valid),
        .o_req   (o_out_req)
    );

endmodule

### rtl/core/avr_prescale.sv
// ----------------------------------------------------------------------------
// avr_prescale: pair selection, gain prescale and quadrant turn
// Picks the rotated pair, scales it by the CORDIC gain (one multiply per
// component), then folds the angle into a quarter turn plus a residual.
// ----------------------------------------------------------------------------
module avr_prescale (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  avr_pkg::t_in_req i_req,
    output logic             o_valid,
    output avr_pkg::t_cord   o_cord,
    output avr_pkg::t_side   o_side
);

    localparam int unsigned W  = avr_pkg::CORDIC_W;
    localparam int unsigned ZW = avr_pkg::ANGLE_W;
    localparam int unsigned PW = avr_pkg::PROD_W;

    // quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic signed [31:0]   w_p;
    logic signed [31:0]   w_q;
    logic signed [PW-1:0] w_prod_p;
    logic signed [PW-1:0] w_prod_q;

    logic                 r_mul_valid;
    logic signed [63:0]   r_prod_p;
    logic signed [63:0]   r_prod_q;
    logic        [31:0]   r_angle;
    avr_pkg::t_side       r_mul_side;

    logic signed [W-1:0]  w_sp;
    logic signed [W-1:0]  w_sq;
    logic        [31:0]   w_biased;
    logic        [1:0]    w_quad;
    logic        [31:0]   w_resid;
    avr_pkg::t_cord       n_cord;

    logic                 r_valid;
    avr_pkg::t_cord       r_cord;
    avr_pkg::t_side       r_side;

    // rotated pair follows the axis cyclically
    always_comb begin
        unique case (i_req.axis_select)
            avr_pkg::AXIS_0: begin
                w_p = i_req.comp_1;
                w_q = i_req.comp_2;
            end
            avr_pkg::AXIS_1: begin
                w_p = i_req.comp_2;
                w_q = i_req.comp_0;
            end
            avr_pkg::AXIS_2: begin
                w_p = i_req.comp_0;
                w_q = i_req.comp_1;
            end
            avr_pkg::AXIS_NONE: begin
                w_p = i_req.comp_1;
                w_q = i_req.comp_2;
            end
        endcase
    end

    // gain prescale, 32 x 33 signed
    assign w_prod_p = PW'(w_p) * PW'(avr_pkg::GAIN_Q32);
    assign w_prod_q = PW'(w_q) * PW'(avr_pkg::GAIN_Q32);

    // multiply stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (i_en) begin
            r_mul_valid <= i_valid;
        end
    end

    // multiply stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_p   <= w_prod_p[63:0];
            r_prod_q   <= w_prod_q[63:0];
            r_angle    <= i_req.turn_angle;
            r_mul_side <= '{comp_0: i_req.comp_0, comp_1: i_req.comp_1,
                            comp_2: i_req.comp_2, axis_select: i_req.axis_select};
        end
    end

    // drop 8 bits, leaving 24 fraction bits
    assign w_sp = W'($signed(r_prod_p[63:8]));
    assign w_sq = W'($signed(r_prod_q[63:8]));

    // nearest quarter turn and the residual in [-2^29, 2^29)
    assign w_biased = r_angle + 32'h2000_0000;
    assign w_quad   = w_biased[31:30];
    assign w_resid  = r_angle - {w_quad, 30'd0};

    always_comb begin
        n_cord.z = ZW'($signed(w_resid));
        unique case (w_quad)
            QUAD_0: begin
                n_cord.x = w_sp;
                n_cord.y = w_sq;
            end
            QUAD_1: begin
                n_cord.x = -w_sq;
                n_cord.y = w_sp;
            end
            QUAD_2: begin
                n_cord.x = -w_sp;
                n_cord.y = -w_sq;
            end
            QUAD_3: begin
                n_cord.x = w_sq;
                n_cord.y = -w_sp;
            end
        endcase
    end

    // quadrant stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_mul_valid;
        end
    end

    // quadrant stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cord <= n_cord;
            r_side <= r_mul_side;
        end
    end

    assign o_valid = r_valid;
    assign o_cord  = r_cord;
    assign o_side  = r_side;

endmodule

### rtl/core/avr_cordic_cell.sv
// ----------------------------------------------------------------------------
// avr_cordic_cell: one CORDIC micro-rotation
// Turns the pair by +/- atan(2^-STAGE) toward a zero residual and passes
// the result and the side data to the next cell.
// ----------------------------------------------------------------------------
module avr_cordic_cell #(
    parameter int unsigned STAGE = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  avr_pkg::t_cord i_cord,
    input  avr_pkg::t_side i_side,
    output logic           o_valid,
    output avr_pkg::t_cord o_cord,
    output avr_pkg::t_side o_side
);

    localparam int unsigned W  = avr_pkg::CORDIC_W;
    localparam int unsigned ZW = avr_pkg::ANGLE_W;
    localparam logic [31:0] ANGLE =
        (STAGE < avr_pkg::ATAN_N) ? avr_pkg::ATAN_TABLE[STAGE] : 32'd0;
    localparam logic signed [ZW-1:0] ANGLE_Z = $signed(ZW'(ANGLE));

    logic signed [W-1:0] w_dx;
    logic signed [W-1:0] w_dy;
    avr_pkg::t_cord      n_cord;

    logic                r_valid;
    avr_pkg::t_cord      r_cord;
    avr_pkg::t_side      r_side;

    // floor shifts of the pair
    assign w_dx = i_cord.x >>> STAGE;
    assign w_dy = i_cord.y >>> STAGE;

    // rotate toward zero residual
    always_comb begin
        if (!i_cord.z[ZW-1]) begin
            n_cord.x = i_cord.x - w_dy;
            n_cord.y = i_cord.y + w_dx;
            n_cord.z = i_cord.z - ANGLE_Z;
        end else begin
            n_cord.x = i_cord.x + w_dy;
            n_cord.y = i_cord.y - w_dx;
            n_cord.z = i_cord.z + ANGLE_Z;
        end
    end

    // cell valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // cell payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cord <= n_cord;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_cord  = r_cord;
    assign o_side  = r_side;

endmodule

### rtl/core/avr_finish.sv
// ----------------------------------------------------------------------------
// avr_finish: rounding, saturation and output register
// Rounds the pair half up to integer scale, clips to 32 bits and places the
// components back at their axes; AXIS_NONE passes the raw vector through.
// ----------------------------------------------------------------------------
module avr_finish (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  avr_pkg::t_cord    i_cord,
    input  avr_pkg::t_side    i_side,
    output logic              o_valid,
    output avr_pkg::t_out_req o_req
);

    localparam int unsigned W  = avr_pkg::CORDIC_W;
    localparam int unsigned FW = avr_pkg::FRAC_W;
    localparam int unsigned RW = W - FW;
    localparam logic signed [W-1:0] HALF = W'(1) <<< (FW - 1);

    logic signed [W-1:0] w_x_sum;
    logic signed [W-1:0] w_y_sum;
    logic signed [31:0]  w_x;
    logic signed [31:0]  w_y;
    logic                w_x_sat;
    logic                w_y_sat;
    avr_pkg::t_out_req   n_req;

    logic                r_valid;
    avr_pkg::t_out_req   r_req;

    // clip a rounded value to the signed 32-bit range
    function automatic logic signed [31:0] clip32(input logic signed [RW-1:0] v);
        logic fits;
        fits = (v[RW-1:31] == '0) || (v[RW-1:31] == '1);
        if (fits) begin
            return v[31:0];
        end else if (v[RW-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

    // round half up
    assign w_x_sum = i_cord.x + HALF;
    assign w_y_sum = i_cord.y + HALF;
    assign w_x     = clip32(w_x_sum[W-1:FW]);
    assign w_y     = clip32(w_y_sum[W-1:FW]);
    assign w_x_sat = !((w_x_sum[W-1:FW+31] == '0) || (w_x_sum[W-1:FW+31] == '1));
    assign w_y_sat = !((w_y_sum[W-1:FW+31] == '0) || (w_y_sum[W-1:FW+31] == '1));

    // components back to their axes
    always_comb begin
        n_req.out_0     = i_side.comp_0;
        n_req.out_1     = i_side.comp_1;
        n_req.out_2     = i_side.comp_2;
        n_req.saturated = w_x_sat || w_y_sat;
        unique case (i_side.axis_select)
            avr_pkg::AXIS_0: begin
                n_req.out_1 = w_x;
                n_req.out_2 = w_y;
            end
            avr_pkg::AXIS_1: begin
                n_req.out_2 = w_x;
                n_req.out_0 = w_y;
            end
            avr_pkg::AXIS_2: begin
                n_req.out_0 = w_x;
                n_req.out_1 = w_y;
            end
            avr_pkg::AXIS_NONE: begin
                n_req.saturated = 1'b0;
            end
        endcase
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_req <= n_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

### rtl/core/avr_checker.sv
// ----------------------------------------------------------------------------
// avr_assertions: port-level checks of the axis vector rotator
// Watches the handshakes and the saturation flag, bound to the top level.
// ----------------------------------------------------------------------------
module avr_assertions (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input avr_pkg::t_out_req o_out_req
);

    // a pending result stays offered
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a pending result keeps its payload
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_req))
        else $error("result changed while stalled");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipe not empty after reset");

    // ready only drops after a request was taken into the skid
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(i_in_valid && o_in_ready && o_out_valid && !i_out_ready))
        else $error("input ready dropped without a stalled request");

    // a clipped result shows a bound on some component
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.saturated |->
            o_out_req.out_0 == 32'sh7FFF_FFFF || o_out_req.out_0 == 32'sh8000_0000 ||
            o_out_req.out_1 == 32'sh7FFF_FFFF || o_out_req.out_1 == 32'sh8000_0000 ||
            o_out_req.out_2 == 32'sh7FFF_FFFF || o_out_req.out_2 == 32'sh8000_0000)
        else $error("saturated flag without a clipped component");

endmodule

bind axis_vector_rotator avr_assertions u_avr_assertions (.*);
